// File: hw/rtl/btfa_pkg.sv
// Shared types and constants for the turbo button block.
package btfa_pkg;

  localparam int BTN_COUNT   = 14;
  localparam int TIME_BITS   = 48;
  localparam int PERIOD_BITS = 32;

  typedef logic [BTN_COUNT-1:0]   btn_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // Toggle arming phase of one channel
  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_WAITING = 2'd1,
    PH_READING = 2'd2
  } phase_t;

  // Item kinds carried in the opcode
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  // Config register indexes
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam period_t PERIOD_RESET = period_t'(50000);

  // Stored state of one button
  typedef struct packed {
    logic   sup;
    logic   turbo;
    logic   syn;
    stamp_t last;
  } lane_state_t;

  // Held / pressed / released bits of one button
  typedef struct packed {
    logic hold;
    logic trig;
    logic rel;
  } lane_bits_t;

endpackage

// File: hw/rtl/btfa_pick.sv
// Lowest-index pick of the newly pressed button that flips turbo.
module btfa_pick (
  input  btfa_pkg::btn_t cand,
  input  logic           arm,
  output btfa_pkg::btn_t pick,
  output logic           found
);
  import btfa_pkg::*;

  // Isolate lowest set bit
  assign pick  = arm ? (cand & (~cand + btn_t'(1))) : '0;
  assign found = arm && (|cand);

endmodule

// File: hw/rtl/btfa_lane.sv
// Per-button turbo logic: suppression, toggle flip, autofire timing.
module btfa_lane (
  input  btfa_pkg::lane_state_t cur,
  input  btfa_pkg::lane_bits_t  bits_in,
  input  logic                  picked,
  input  btfa_pkg::stamp_t      now,
  input  btfa_pkg::period_t     period,
  output btfa_pkg::lane_state_t nxt,
  output btfa_pkg::lane_bits_t  bits_out
);
  import btfa_pkg::*;

  stamp_t age;
  logic   fire;

  assign age  = now - cur.last;
  assign fire = age >= stamp_t'(period);

  always_comb begin
    nxt      = cur;
    bits_out = bits_in;
    if (cur.sup) begin
      // hidden until released
      nxt.sup  = bits_in.hold && !bits_in.rel;
      bits_out = '0;
    end else if (picked) begin
      nxt.turbo = !cur.turbo;
      nxt.sup   = 1'b1;
      nxt.last  = '0;
      bits_out  = '0;
    end else if (bits_in.trig) begin
      nxt.syn  = 1'b1;
      nxt.last = now;
    end else if (bits_in.rel) begin
      nxt.syn  = 1'b0;
      nxt.last = '0;
    end else if (bits_in.hold && cur.turbo) begin
      if (fire) begin
        // synthetic press or release
        nxt.last      = now;
        nxt.syn       = !cur.syn;
        bits_out.hold = !cur.syn;
        bits_out.trig = !cur.syn;
        bits_out.rel  = cur.syn;
      end else begin
        bits_out.hold = cur.syn;
      end
    end
  end

endmodule

// File: hw/rtl/button_turbo_autofire.sv
// Top level of the turbo (autofire) button block.
//
// Input stream s_*: one word per button sample or toggle request.
// s_tuser holds the opcode and the pad channel, s_tdata the three button
// masks and the timestamp. Output stream m_*: one result word per input
// word, in order: modified masks, the channel's turbo mask and phase.
// Config port cfg_*: index 0 enable, index 1 turbo period; write it only
// while no word is in flight.
// A word accepted into the input register moves on into the result register and is
// presented on m_tvalid from there. Throughput: one word per cycle while the
// result is not stalled; the per-channel state is read and rewritten in the same
// cycle that moves a word from the input register to the result register.
// Reset (rst, synchronous) clears all channel state, sets enable to 1 and
// the period to 50000 ticks, and empties both registers.
// When m_tready is low the result holds; one more word is taken into the
// input register, after which s_tready drops until the result is taken.
module button_turbo_autofire #(
  parameter int NUM_PADS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // held, pressed, released, timestamp
  input  logic [1:0]  s_tuser,   // opcode, pad_channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // held_out, pressed_out, released_out, turbo_mask,
                                 // toggle_phase
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import btfa_pkg::*;

  localparam int PAD_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  // Config registers
  logic    enable;
  period_t period;

  // Input register
  logic   q_valid;
  logic   q_op;
  logic   q_chan;
  btn_t   q_held;
  btn_t   q_pressed;
  btn_t   q_released;
  stamp_t q_now;

  // Result register
  logic        out_valid;
  logic [63:0] out_data;
  logic [63:0] out_data_next;

  // Channel state
  stamp_t last_time [NUM_PADS][BTN_COUNT];
  btn_t   turbo     [NUM_PADS];
  btn_t   syn       [NUM_PADS];
  btn_t   sup       [NUM_PADS];
  phase_t phase     [NUM_PADS];

  logic             advance;
  logic             ch_ok;
  logic [PAD_W-1:0] idx;
  phase_t           phase_cur;
  phase_t           phase_wait;
  phase_t           phase_next;
  phase_t           phase_tog;
  btn_t             turbo_cur;
  btn_t             syn_cur;
  btn_t             sup_cur;
  btn_t             cand;
  btn_t             pick;
  logic             found;
  btn_t             hold_o;
  btn_t             trig_o;
  btn_t             rel_o;
  btn_t             turbo_n;
  btn_t             syn_n;
  btn_t             sup_n;
  stamp_t           last_n [BTN_COUNT];
  lane_state_t      lane_cur [BTN_COUNT];
  lane_state_t      lane_nxt [BTN_COUNT];
  lane_bits_t       lane_in  [BTN_COUNT];
  lane_bits_t       lane_out [BTN_COUNT];

  // Handshake
  assign advance  = q_valid && (!out_valid || m_tready);
  assign s_tready = !q_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Channel select
  assign ch_ok     = int'(q_chan) < NUM_PADS;
  assign idx       = PAD_W'(q_chan);
  assign phase_cur = phase[idx];
  assign turbo_cur = turbo[idx];
  assign syn_cur   = syn[idx];
  assign sup_cur   = sup[idx];
  assign phase_tog = (phase_cur == PH_NORMAL) ? PH_WAITING : PH_NORMAL;

  // Arming: all released moves waiting to reading
  assign phase_wait = (phase_cur == PH_WAITING && q_held == '0) ? PH_READING : phase_cur;
  assign cand       = q_pressed & ~sup_cur;
  assign phase_next = found ? PH_NORMAL : phase_wait;

  btfa_pick u_pick (
    .cand  (cand),
    .arm   (phase_wait == PH_READING),
    .pick  (pick),
    .found (found)
  );

  // Button lanes
  for (genvar b = 0; b < BTN_COUNT; b++) begin : g_lane
    assign lane_cur[b] = '{sup: sup_cur[b], turbo: turbo_cur[b], syn: syn_cur[b],
                           last: last_time[idx][b]};
    assign lane_in[b]  = '{hold: q_held[b], trig: q_pressed[b], rel: q_released[b]};

    btfa_lane u_lane (
      .cur      (lane_cur[b]),
      .bits_in  (lane_in[b]),
      .picked   (pick[b]),
      .now      (q_now),
      .period   (period),
      .nxt      (lane_nxt[b]),
      .bits_out (lane_out[b])
    );

    assign hold_o[b]  = lane_out[b].hold;
    assign trig_o[b]  = lane_out[b].trig;
    assign rel_o[b]   = lane_out[b].rel;
    assign turbo_n[b] = lane_nxt[b].turbo;
    assign syn_n[b]   = lane_nxt[b].syn;
    assign sup_n[b]   = lane_nxt[b].sup;
    assign last_n[b]  = lane_nxt[b].last;
  end

  // Result word
  always_comb begin
    out_data_next = '0;
    if (!ch_ok) begin
      if (q_op == OP_SAMPLE) begin
        out_data_next[41:0] = {q_released, q_pressed, q_held};
      end
    end else if (q_op == OP_TOGGLE) begin
      out_data_next[57:42] = {phase_tog, turbo_cur};
    end else if (!enable) begin
      out_data_next[57:0] = {phase_cur, turbo_cur, q_released, q_pressed, q_held};
    end else begin
      out_data_next[57:0] = {phase_next, turbo_n, rel_o, trig_o, hold_o};
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable <= cfg_wdata[0];
        REG_PERIOD: period <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_tready) begin
      q_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      q_op       <= s_tuser[0];
      q_chan     <= s_tuser[1];
      q_held     <= s_tdata[13:0];
      q_pressed  <= s_tdata[27:14];
      q_released <= s_tdata[41:28];
      q_now      <= s_tdata[89:42];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_PADS; c++) begin
        turbo[c] <= '0;
        syn[c]   <= '0;
        sup[c]   <= '0;
        phase[c] <= PH_NORMAL;
        for (int b = 0; b < BTN_COUNT; b++) begin
          last_time[c][b] <= '0;
        end
      end
    end else if (advance && ch_ok) begin
      if (q_op == OP_TOGGLE) begin
        phase[idx] <= phase_tog;
      end else if (enable) begin
        phase[idx] <= phase_next;
        turbo[idx] <= turbo_n;
        syn[idx]   <= syn_n;
        sup[idx]   <= sup_n;
        for (int b = 0; b < BTN_COUNT; b++) begin
          last_time[idx][b] <= last_n[b];
        end
      end
    end
  end

endmodule

// File: hw/rtl/btfa_check.sv
// Port-level checker for the turbo button block, bound to the top level.
module btfa_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // Both registers empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not empty after reset");

  // Input stalls only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // Phase code three is never reported
  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[57:56] != 2'b11)
    else $error("invalid toggle phase in result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind button_turbo_autofire btfa_check u_btfa_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
